// ----- src/mad_pkg.sv -----
// Package for the centered moving-average detrend block.
// Holds the beat structs, fixed field widths and the sequencer states.
// No dependencies.
package mad_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int DET_BITS    = SAMPLE_BITS + 1;
    localparam int CFG_BITS    = 5;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_in;
    } in_beat_t;

    typedef struct packed {
        logic signed [DET_BITS-1:0] detrended;
        logic                       last_out;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CTR,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

// ----- src/moving_average_detrend.sv -----
// Top level of the centered moving-average detrend block.
// Depends on mad_pkg (beat structs, widths, state enum).
//
// Usage: s_ channel takes one sample per beat with last_in closing the signal;
// m_ channel returns sample minus the truncated mean of the 2*h+1 samples
// centered on it. cfg_we/cfg_wdata set the half width h, latched at the first
// sample of each signal (0 reads as 1, above MAX_HALF saturates).
// Outputs lag the input by h samples; the last beat flushes the remaining ones
// and the final output carries last_out.
// Timing: each window step reads the sample ring twice (one read port) and
// then runs a restoring divider one quotient bit a cycle; a last beat costs
// h+1 steps. s_ready is high only between steps; one finished beat waits in
// the output register, so the next sample is taken and worked on while the
// receiver stalls, and the sequencer holds only when a second result is ready.
// Reset clears control state and sets h to 1; the ring needs no clearing,
// since only entries written in the current signal are ever used.
module moving_average_detrend #(
    parameter int MAX_HALF = 31
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  mad_pkg::in_beat_t                      s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output mad_pkg::out_beat_t                     m_data,
    input  logic                                   cfg_we,
    input  logic [mad_pkg::CFG_BITS-1:0]           cfg_wdata
);

    localparam int SB    = mad_pkg::SAMPLE_BITS;
    localparam int DB    = mad_pkg::DET_BITS;
    localparam int RING  = 2 * MAX_HALF + 1;
    localparam int AW    = $clog2(RING);
    localparam int HW    = $clog2(MAX_HALF + 1);
    localparam int WW    = HW + 1;
    localparam int SUMW  = SB + $clog2(RING);
    localparam int CW    = $clog2(SUMW);
    localparam int PW    = $clog2(2 * MAX_HALF + 3);
    localparam int HCW   = (HW > mad_pkg::CFG_BITS) ? HW : mad_pkg::CFG_BITS;

    localparam logic [AW:0]     RING_C  = (AW+1)'(RING);
    localparam logic [HCW-1:0]  MAX_C   = HCW'(MAX_HALF);
    localparam logic [PW-1:0]   POS_MAX = {PW{1'b1}};
    localparam logic [CW-1:0]   DIV_END = CW'(SUMW - 1);

    function automatic logic [AW-1:0] ring_sub(input logic [AW-1:0] a, input logic [AW:0] b);
        logic [AW:0] t;
        t = {1'b0, a} + RING_C - b;
        if (t >= RING_C) begin
            t = t - RING_C;
        end
        return t[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
        return (a == AW'(RING - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] p);
        return (p == POS_MAX) ? p : p + 1'b1;
    endfunction

    // Sample ring
    logic signed [SB-1:0] ring_mem [RING];
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic signed [SB-1:0] rd_data_reg;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic signed [SB-1:0] wr_data;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= ring_mem[rd_addr];
        end
        if (wr_en) begin
            ring_mem[wr_addr] <= wr_data;
        end
    end

    mad_pkg::state_t state_reg, state_next;
    logic [mad_pkg::CFG_BITS-1:0] cfg_reg;
    logic [HW-1:0]        h_reg, h_next;
    logic [HW-1:0]        k_reg, k_next;
    logic [AW-1:0]        wptr_reg, wptr_next;
    logic [AW-1:0]        old_ptr_reg, old_ptr_next;
    logic [AW-1:0]        ctr_ptr_reg, ctr_ptr_next;
    logic [PW-1:0]        cnt_reg, cnt_next;
    logic [PW-1:0]        pos_reg, pos_next;
    logic signed [SB-1:0] x_reg, x_next;
    logic                 last_reg, last_next;
    logic signed [SB-1:0] first_reg, first_next;
    logic signed [SB-1:0] old_reg, old_next;
    logic signed [SB-1:0] ctr_reg, ctr_next;
    logic signed [SUMW-1:0] sum_reg, sum_next;
    logic [SUMW-1:0]      dq_reg, dq_next;
    logic [WW-1:0]        dr_reg, dr_next;
    logic [CW-1:0]        dcnt_reg, dcnt_next;
    logic                 neg_reg, neg_next;
    logic                 m_valid_reg, m_valid_next;
    mad_pkg::out_beat_t   m_data_reg, m_data_next;

    logic                 accept;
    logic                 is_first;
    logic [HCW-1:0]       cfg_ext;
    logic [HW-1:0]        h_cfg;
    logic [HW-1:0]        h_use;
    logic [WW-1:0]        w_use;
    logic [WW-1:0]        w_cur;
    logic [AW-1:0]        wptr_use;
    logic                 old_valid;
    logic                 ctr_valid;
    logic signed [SUMW-1:0] sum_upd;
    logic signed [SUMW-1:0] sum_init;
    logic [WW:0]          r_sh;
    logic [SUMW-1:0]      q_signed;
    logic                 out_load;
    logic                 flush_more;
    logic                 final_step;

    assign accept   = s_valid && s_ready;
    assign is_first = (cnt_reg == '0);
    assign cfg_ext  = HCW'(cfg_reg);
    assign h_cfg    = (cfg_ext == '0) ? HW'(1) :
                      (cfg_ext > MAX_C) ? HW'(MAX_HALF) : cfg_ext[HW-1:0];
    assign h_use    = is_first ? h_cfg : h_reg;
    assign w_use    = {h_use, 1'b1};
    assign w_cur    = {h_reg, 1'b1};
    assign wptr_use = is_first ? '0 : wptr_reg;

    // window edge positions exist once enough samples of the signal are in
    assign old_valid = pos_reg >= PW'({h_reg, 1'b0}) + PW'(2);
    assign ctr_valid = pos_reg >= PW'(h_reg) + PW'(1);

    assign sum_init = $signed({{(SUMW-WW){1'b0}}, w_use})
                    * $signed({{(SUMW-SB){s_data.sample[SB-1]}}, s_data.sample});
    assign sum_upd  = sum_reg + SUMW'(x_reg) - SUMW'(old_reg);
    assign r_sh     = {dr_reg, dq_reg[SUMW-1]};
    assign q_signed = neg_reg ? (~dq_reg + 1'b1) : dq_reg;
    assign out_load = !m_valid_reg || m_ready;
    assign final_step = last_reg && (k_reg == h_reg);
    assign flush_more = last_reg && (k_reg != h_reg);

    assign s_ready = (state_reg == mad_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        h_next       = h_reg;
        k_next       = k_reg;
        wptr_next    = wptr_reg;
        old_ptr_next = old_ptr_reg;
        ctr_ptr_next = ctr_ptr_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        x_next       = x_reg;
        last_next    = last_reg;
        first_next   = first_reg;
        old_next     = old_reg;
        ctr_next     = ctr_reg;
        sum_next     = sum_reg;
        dq_next      = dq_reg;
        dr_next      = dr_reg;
        dcnt_next    = dcnt_reg;
        neg_next     = neg_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        rd_en        = 1'b0;
        rd_addr      = old_ptr_reg;
        wr_en        = 1'b0;
        wr_addr      = wptr_use;
        wr_data      = s_data.sample;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            mad_pkg::ST_IDLE: begin
                if (accept) begin
                    // old edge is read in the same edge as the write: read-first
                    rd_en        = 1'b1;
                    rd_addr      = ring_sub(wptr_use, (AW+1)'(w_use));
                    wr_en        = 1'b1;
                    old_ptr_next = rd_addr;
                    ctr_ptr_next = ring_sub(wptr_use, (AW+1)'(h_use));
                    wptr_next    = ring_inc(wptr_use);
                    h_next       = h_use;
                    k_next       = '0;
                    x_next       = s_data.sample;
                    last_next    = s_data.last_in;
                    cnt_next     = is_first ? PW'(1) : pos_inc(cnt_reg);
                    pos_next     = cnt_next;
                    if (is_first) begin
                        first_next = s_data.sample;
                        sum_next   = sum_init;
                    end
                    state_next = mad_pkg::ST_CTR;
                end
            end
            mad_pkg::ST_CTR: begin
                old_next   = old_valid ? rd_data_reg : first_reg;
                rd_en      = 1'b1;
                rd_addr    = ctr_ptr_reg;
                state_next = mad_pkg::ST_SUM;
            end
            mad_pkg::ST_SUM: begin
                ctr_next = rd_data_reg;
                sum_next = sum_upd;
                if (ctr_valid) begin
                    neg_next   = sum_upd[SUMW-1];
                    dq_next    = sum_upd[SUMW-1] ? (~sum_upd + 1'b1) : sum_upd;
                    dr_next    = '0;
                    dcnt_next  = '0;
                    state_next = mad_pkg::ST_DIV;
                end else if (flush_more) begin
                    k_next       = k_reg + 1'b1;
                    old_ptr_next = ring_inc(old_ptr_reg);
                    ctr_ptr_next = ring_inc(ctr_ptr_reg);
                    pos_next     = pos_inc(pos_reg);
                    rd_en        = 1'b1;
                    rd_addr      = old_ptr_next;
                    state_next   = mad_pkg::ST_CTR;
                end else begin
                    state_next = mad_pkg::ST_IDLE;
                end
            end
            mad_pkg::ST_DIV: begin
                if (r_sh >= {1'b0, w_cur}) begin
                    dr_next = WW'(r_sh - {1'b0, w_cur});
                    dq_next = {dq_reg[SUMW-2:0], 1'b1};
                end else begin
                    dr_next = r_sh[WW-1:0];
                    dq_next = {dq_reg[SUMW-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DIV_END) begin
                    state_next = mad_pkg::ST_OUT;
                end
            end
            mad_pkg::ST_OUT: begin
                if (out_load) begin
                    m_valid_next          = 1'b1;
                    m_data_next.detrended = DB'(ctr_reg) - q_signed[DB-1:0];
                    m_data_next.last_out  = final_step;
                    if (flush_more) begin
                        k_next       = k_reg + 1'b1;
                        old_ptr_next = ring_inc(old_ptr_reg);
                        ctr_ptr_next = ring_inc(ctr_ptr_reg);
                        pos_next     = pos_inc(pos_reg);
                        rd_en        = 1'b1;
                        rd_addr      = old_ptr_next;
                        state_next   = mad_pkg::ST_CTR;
                    end else begin
                        if (last_reg) begin
                            cnt_next = '0;
                        end
                        state_next = mad_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = mad_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mad_pkg::ST_IDLE;
            cfg_reg     <= mad_pkg::CFG_BITS'(1);
            h_reg       <= HW'(1);
            k_reg       <= '0;
            cnt_reg     <= '0;
            pos_reg     <= '0;
            last_reg    <= 1'b0;
            sum_reg     <= '0;
            first_reg   <= '0;
            wptr_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            if (cfg_we) begin
                cfg_reg <= cfg_wdata;
            end
            h_reg       <= h_next;
            k_reg       <= k_next;
            cnt_reg     <= cnt_next;
            pos_reg     <= pos_next;
            last_reg    <= last_next;
            sum_reg     <= sum_next;
            first_reg   <= first_next;
            wptr_reg    <= wptr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        old_ptr_reg <= old_ptr_next;
        ctr_ptr_reg <= ctr_ptr_next;
        x_reg       <= x_next;
        old_reg     <= old_next;
        ctr_reg     <= ctr_next;
        dq_reg      <= dq_next;
        dr_reg      <= dr_next;
        dcnt_reg    <= dcnt_next;
        neg_reg     <= neg_next;
        m_data_reg  <= m_data_next;
    end

    a_half_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (h_reg != '0) && (HCW'(h_reg) <= MAX_C))
        else $error("half width out of range");

    a_flush_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        k_reg <= h_reg)
        else $error("flush step beyond half width");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == mad_pkg::ST_CTR))
        else $error("accepted beat did not start a step");

    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mad_pkg::ST_OUT && out_load && final_step) |=> (cnt_reg == '0))
        else $error("signal not restarted after final output");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mad_pkg::ST_OUT && !out_load) |=> (state_reg == mad_pkg::ST_OUT))
        else $error("result dropped while output register full");

endmodule

// ----- sim/testbench.sv -----
// Testbench for moving_average_detrend: drives signals of random length,
// content and half width, predicts every output beat and checks it.
// Depends on mad_pkg and the RTL under src/.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_LEN   = 63;
    localparam int CYCLE_CAP  = 3_000_000;
    localparam int ITEM_GOAL  = 400;
    localparam int SETTLE     = 40;

    class detrend_scoreboard;
        logic signed [mad_pkg::SAMPLE_BITS-1:0] ring[RING_LEN];
        int                 wr_ptr;
        int                 seen;
        int                 cur_half;
        int                 half_reg;
        mad_pkg::out_beat_t pending_outs[$];
        int                 errors;

        function new();
            wr_ptr   = 0;
            seen     = 0;
            cur_half = 1;
            half_reg = 1;
            errors   = 0;
        endfunction

        // sample d positions back from the newest
        function int at_back(int d);
            return ring[(wr_ptr + RING_LEN - 1 - d) % RING_LEN];
        endfunction

        function void note_sample(mad_pkg::in_beat_t b);
            int                 h, w, emax, emin, sum, d;
            mad_pkg::out_beat_t o;
            if (seen == 0) begin
                h = (half_reg < 1) ? 1 : half_reg;
                cur_half = h;
                for (int i = 0; i < RING_LEN; i++) ring[i] = b.sample;
                wr_ptr = 0;
            end
            h = cur_half;
            w = 2 * h + 1;
            ring[wr_ptr] = b.sample;
            wr_ptr = (wr_ptr + 1) % RING_LEN;
            if (seen < h + 1) seen++;
            emax = seen - 1;
            if (!b.last_in) begin
                if (seen < h + 1) return;
                emin = h;
            end else begin
                emin = 0;
            end
            for (int e = emax; e >= emin; e--) begin
                sum = 0;
                for (int t = 0; t < w; t++) begin
                    d = e + h - t;
                    if (d < 0) d = 0;   // past the newest reads the last sample
                    sum += at_back(d);
                end
                o.detrended = mad_pkg::DET_BITS'(at_back(e) - sum / w);
                o.last_out  = b.last_in && (e == 0);
                pending_outs.push_back(o);
            end
            if (b.last_in) seen = 0;
        endfunction

        function void check_output(mad_pkg::out_beat_t got);
            mad_pkg::out_beat_t exp_beat;
            if (pending_outs.size() == 0) begin
                $error("unexpected output beat detrended=%0d last_out=%0b",
                       got.detrended, got.last_out);
                errors++;
                return;
            end
            exp_beat = pending_outs.pop_front();
            if (got.detrended !== exp_beat.detrended) begin
                $error("detrended: expected %0d, actual %0d",
                       exp_beat.detrended, got.detrended);
                errors++;
            end
            if (got.last_out !== exp_beat.last_out) begin
                $error("last_out: expected %0b, actual %0b",
                       exp_beat.last_out, got.last_out);
                errors++;
            end
        endfunction
    endclass

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    mad_pkg::in_beat_t            s_data;
    logic                         m_valid;
    logic                         m_ready;
    mad_pkg::out_beat_t           m_data;
    logic                         cfg_we;
    logic [mad_pkg::CFG_BITS-1:0] cfg_wdata;

    detrend_scoreboard sb;
    int s_idle_pct;
    int m_stall_pct;
    int hold_left;
    int items_sent;
    int cycles = 0;

    moving_average_detrend uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        hold_left = 0;
        s_idle_pct  = 0;
        m_stall_pct = 0;
        sb = new();
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("moving_average_detrend: mismatch");
            $finish;
        end
    end

    // receiver: checks beats, stalls at random, and a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) sb.check_output(m_data);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= m_stall_pct);
            end
        end
    end

    task automatic send_beat(input logic signed [mad_pkg::SAMPLE_BITS-1:0] smp,
                             input logic lst);
        mad_pkg::in_beat_t b;
        b.sample  = smp;
        b.last_in = lst;
        if ($urandom_range(0, 99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < s_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(b);
        items_sent++;
    endtask

    // kind 0: full range, 1: extremes, 2: small values near zero
    task automatic send_signal(input int len, input int kind);
        logic signed [mad_pkg::SAMPLE_BITS-1:0] smp;
        for (int i = 0; i < len; i++) begin
            unique case (kind)
                1:       smp = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                2:       smp = $signed(16'($urandom_range(0, 15))) - 16'sd8;
                default: smp = 16'($urandom);
            endcase
            send_beat(smp, i == len - 1);
        end
    endtask

    task automatic drain_and_settle();
        s_valid <= 1'b0;
        while (sb.pending_outs.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // only called with the block idle
    task automatic write_half(input int v);
        cfg_we    <= 1'b1;
        cfg_wdata <= mad_pkg::CFG_BITS'(v);
        @(posedge aclk);
        sb.half_reg = v;
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int h, len, sig_no;
        items_sent = 0;
        sig_no     = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset width, a one-sample signal, extremes, zero and max width
        send_beat(16'sh7fff, 1'b1);
        send_beat(16'sh8000, 1'b0);
        send_beat(16'sh7fff, 1'b0);
        send_beat(16'sh8000, 1'b0);
        send_beat(16'sh0000, 1'b1);
        drain_and_settle();
        write_half(0);
        send_signal(4, 1);
        drain_and_settle();
        write_half(31);
        send_signal(3, 1);          // shorter than the half width
        drain_and_settle();
        send_signal(8, 0);
        drain_and_settle();

        while (items_sent < ITEM_GOAL) begin
            unique case ((sig_no / 6) % 4)
                0: begin s_idle_pct = 0;  m_stall_pct = 0;  end
                1: begin s_idle_pct = 57; m_stall_pct = 0;  end
                2: begin s_idle_pct = 0;  m_stall_pct = 57; end
                default: begin s_idle_pct = 7; m_stall_pct = 7; end
            endcase
            h = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 4);
            write_half(h);
            if (h < 1) h = 1;
            len = $urandom_range(1, 2 * h + 6);
            if (sig_no == 1) begin
                len = 30;
                hold_left = 400;    // receiver backs off, sender keeps pushing
            end
            send_signal(len, ($urandom_range(0, 5) == 0) ? 1 :
                             ($urandom_range(0, 3) == 0) ? 2 : 0);
            drain_and_settle();
            sig_no++;
        end

        if (sb.errors == 0) begin
            $display("moving_average_detrend: match");
        end else begin
            $display("moving_average_detrend: mismatch");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/mad_pkg.sv
src/moving_average_detrend.sv
sim/testbench.sv
